### rtl/gmls_pkg.sv
// ----------------------------------------------------------------------------
// gmls_pkg
// Shared types and constants for the grid memory with line select.
// ----------------------------------------------------------------------------
package gmls_pkg;

  localparam int GRID_SIDE = 16;
  localparam int COORD_W   = $clog2(GRID_SIDE);
  localparam int ADDR_W    = 2 * COORD_W;
  localparam int CELLS     = GRID_SIDE * GRID_SIDE;
  localparam int VALUE_W   = 16;
  localparam int FUNC_W    = 3;

  localparam logic signed [VALUE_W-1:0] COORD_MAX = VALUE_W'(GRID_SIDE - 1);

  typedef enum logic [FUNC_W-1:0] {
    FN_SET_COL = 3'd0,
    FN_SET_ROW = 3'd1,
    FN_WRITE   = 3'd2,
    FN_READ    = 3'd3,
    FN_TOGGLE  = 3'd4,
    FN_ROW_SEL = 3'd5,
    FN_COL_SEL = 3'd6
  } func_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_TOGGLE,
    S_WALK,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [VALUE_W-1:0] wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
  } mem_req_t;

endpackage

### rtl/gmls_grid.sv
// ----------------------------------------------------------------------------
// gmls_grid
// Cell storage: one write port, one registered read port. Per-cell valid
// bits make unwritten cells read as zero right after reset.
// ----------------------------------------------------------------------------
module gmls_grid (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gmls_pkg::mem_req_t        req,
  output logic [gmls_pkg::VALUE_W-1:0] rd_data
);
  import gmls_pkg::*;

  logic [VALUE_W-1:0] mem_q [CELLS];
  logic [CELLS-1:0]   vld_r;
  logic [VALUE_W-1:0] rd_data_r;
  logic               rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_q[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem_q[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.we) begin
        vld_r[req.waddr] <= 1'b1;
      end
      if (req.re) begin
        rd_vld_r <= vld_r[req.raddr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

### rtl/grid_memory_with_line_select_top.sv
// ----------------------------------------------------------------------------
// grid_memory_with_line_select_top
// 16 x 16 grid of signed cells with a cursor, read/write/toggle and one-hot
// row or column select.
// ----------------------------------------------------------------------------
// Set column, set row and write need no further state; read and toggle do one
// grid memory read, then use it. A read result passes through the grid read
// register and then the output register, and waits while the output is full.
// A line select does one memory read per cell, the last cell check and the
// flush of the held last word, and stalls while a result cannot be passed on.
// Reset clears the cursor and all cell valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module grid_memory_with_line_select_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [gmls_pkg::FUNC_W-1:0]          in_func,
  input  logic signed [gmls_pkg::VALUE_W-1:0]  in_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [gmls_pkg::COORD_W-1:0]         out_col,
  output logic [gmls_pkg::COORD_W-1:0]         out_row,
  output logic signed [gmls_pkg::VALUE_W-1:0]  out_cell_res,
  output logic                                 out_last
);
  import gmls_pkg::*;

  state_t               state_r, state_nxt;
  logic [COORD_W-1:0]   cur_col_r, cur_col_nxt;
  logic [COORD_W-1:0]   cur_row_r, cur_row_nxt;
  logic                 along_row_r, along_row_nxt;
  logic [VALUE_W-1:0]   value_r, value_nxt;
  logic [COORD_W:0]     idx_r, idx_nxt;
  logic                 pend_r, pend_nxt;
  logic [COORD_W-1:0]   pidx_r, pidx_nxt;
  logic                 hold_vld_r, hold_vld_nxt;
  logic [COORD_W-1:0]   hold_col_r, hold_col_nxt;
  logic [COORD_W-1:0]   hold_row_r, hold_row_nxt;
  logic [VALUE_W-1:0]   hold_cell_r, hold_cell_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0]   out_col_r, out_col_nxt;
  logic [COORD_W-1:0]   out_row_r, out_row_nxt;
  logic [VALUE_W-1:0]   out_cell_r, out_cell_nxt;
  logic                 out_last_r, out_last_nxt;

  mem_req_t             mem_req;
  logic [VALUE_W-1:0]   rd_data;

  logic                 accept;
  logic                 slot_free;
  logic [COORD_W-1:0]   clamp_coord;
  logic [ADDR_W-1:0]    cur_addr;
  logic [ADDR_W-1:0]    line_raddr;
  logic [COORD_W-1:0]   p_col;
  logic [COORD_W-1:0]   p_row;
  logic                 hit;
  logic                 cell_nz;
  logic                 emit_need;
  logic                 stall;

  gmls_grid u_grid (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_col      = out_col_r;
  assign out_row      = out_row_r;
  assign out_cell_res = out_cell_r;
  assign out_last     = out_last_r;

  assign clamp_coord = (in_value < 0)         ? '0 :
                       (in_value > COORD_MAX) ? COORD_W'(GRID_SIDE - 1) :
                                                in_value[COORD_W-1:0];

  assign cur_addr   = {cur_row_r, cur_col_r};
  assign line_raddr = along_row_r ? {cur_row_r, idx_r[COORD_W-1:0]}
                                  : {idx_r[COORD_W-1:0], cur_col_r};
  assign p_col      = along_row_r ? pidx_r : cur_col_r;
  assign p_row      = along_row_r ? cur_row_r : pidx_r;
  assign hit        = (value_r == {{(VALUE_W-COORD_W){1'b0}}, pidx_r});
  assign cell_nz    = (rd_data != '0);
  assign emit_need  = pend_r && (hit || cell_nz);
  assign stall      = emit_need && hold_vld_r && !slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      pend_r      <= 1'b0;
      hold_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      pend_r      <= pend_nxt;
      hold_vld_r  <= hold_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    along_row_r <= along_row_nxt;
    value_r     <= value_nxt;
    idx_r       <= idx_nxt;
    pidx_r      <= pidx_nxt;
    hold_col_r  <= hold_col_nxt;
    hold_row_r  <= hold_row_nxt;
    hold_cell_r <= hold_cell_nxt;
    out_col_r   <= out_col_nxt;
    out_row_r   <= out_row_nxt;
    out_cell_r  <= out_cell_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    along_row_nxt = along_row_r;
    value_nxt     = value_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pidx_nxt      = pidx_r;
    hold_vld_nxt  = hold_vld_r;
    hold_col_nxt  = hold_col_r;
    hold_row_nxt  = hold_row_r;
    hold_cell_nxt = hold_cell_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_cell_nxt  = out_cell_r;
    out_last_nxt  = out_last_r;
    mem_req       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_func) inside
            FN_SET_COL: cur_col_nxt = clamp_coord;
            FN_SET_ROW: cur_row_nxt = clamp_coord;
            FN_WRITE: begin
              mem_req.we    = 1'b1;
              mem_req.waddr = cur_addr;
              mem_req.wdata = in_value;
            end
            FN_READ: begin
              if (in_value > 0) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = cur_addr;
                state_nxt     = S_READ;
              end
            end
            FN_TOGGLE: begin
              if (in_value > 0) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = cur_addr;
                state_nxt     = S_TOGGLE;
              end
            end
            FN_ROW_SEL, FN_COL_SEL: begin
              if (in_value >= 0) begin
                along_row_nxt = (in_func == FN_ROW_SEL);
                value_nxt     = in_value;
                idx_nxt       = '0;
                pend_nxt      = 1'b0;
                state_nxt     = S_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = cur_col_r;
          out_row_nxt   = cur_row_r;
          out_cell_nxt  = rd_data;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_TOGGLE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cur_addr;
        mem_req.wdata = cell_nz ? '0 : VALUE_W'(1);
        state_nxt     = S_IDLE;
      end
      S_WALK: begin
        if (!stall) begin
          if (pend_r && (hit || cell_nz)) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = {p_row, p_col};
            mem_req.wdata = hit ? VALUE_W'(1) : '0;
          end
          if (emit_need) begin
            if (hold_vld_r) begin
              out_valid_nxt = 1'b1;
              out_col_nxt   = hold_col_r;
              out_row_nxt   = hold_row_r;
              out_cell_nxt  = hold_cell_r;
              out_last_nxt  = 1'b0;
            end
            hold_vld_nxt  = 1'b1;
            hold_col_nxt  = p_col;
            hold_row_nxt  = p_row;
            hold_cell_nxt = hit ? VALUE_W'(1) : '0;
          end
          if (!idx_r[COORD_W]) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = line_raddr;
            idx_nxt       = idx_r + 1'b1;
            pend_nxt      = 1'b1;
            pidx_nxt      = idx_r[COORD_W-1:0];
          end else begin
            pend_nxt = 1'b0;
            if (!pend_r) begin
              state_nxt = S_FLUSH;
            end
          end
        end
      end
      S_FLUSH: begin
        if (!hold_vld_r) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = hold_col_r;
          out_row_nxt   = hold_row_r;
          out_cell_nxt  = hold_cell_r;
          out_last_nxt  = 1'b1;
          hold_vld_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("grid read and write hit the same cell");

  a_hold_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    hold_vld_r |-> (state_r == S_WALK || state_r == S_FLUSH))
    else $error("held result outside a line select");

  a_walk_wdata: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && mem_req.we) |-> (mem_req.wdata == '0 || mem_req.wdata == 1))
    else $error("line select wrote a value other than 0 or 1");

  a_pend_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_WALK))
    else $error("pending cell outside a line select");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && stall) |=> (state_r == S_WALK && $stable(idx_r)))
    else $error("line select advanced during a stall");
`endif

endmodule
